// File: rtl/assert_macros.svh
// assertion macros used by the pdl_back module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define PDL_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, checked out of reset
`define PDL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/pdl_pkg.sv
// types and constants of the position delay line
package pdl_pkg;

  localparam int unsigned POS_W  = 32;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned RANK_W = 8;
  localparam int unsigned ENTRY_W = POS_W + VAL_W + RANK_W;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_SEAM   = 1'b1;

  localparam logic [POS_W-1:0] RESET_DELAY_UM = 32'd100;

  typedef struct packed {
    logic                     seam;
    logic                     has_bound;
    logic [POS_W-1:0]         bound;
    logic [POS_W-1:0]         pos;
    logic signed [VAL_W-1:0]  value;
    logic [RANK_W-1:0]        rank;
  } cmd_t;

endpackage

// File: rtl/pdl_ram.sv
// generic single write, single read ram with registered read
module pdl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_o <= wdata_i;
    end else begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/pdl_front.sv
// front end: delay register, command accept and classification
module pdl_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         req_type_i,
  input  logic [pdl_pkg::POS_W-1:0]    position_um_i,
  input  logic signed [pdl_pkg::VAL_W-1:0] data_value_i,
  input  logic [pdl_pkg::RANK_W-1:0]   data_rank_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pdl_pkg::POS_W-1:0]    cfg_data_i,
  input  logic                         fifo_full_i,
  output logic                         push_o,
  output pdl_pkg::cmd_t                cmd_o
);

  logic [pdl_pkg::POS_W-1:0] delay_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= pdl_pkg::RESET_DELAY_UM;
    end else if (cfg_valid_i && cfg_ready_o) begin
      delay_q <= cfg_data_i;
    end
  end

  assign busy   = fifo_full_i;
  assign push_o = start && !busy;

  always_comb begin
    cmd_o.seam      = (req_type_i == pdl_pkg::REQ_SEAM);
    cmd_o.has_bound = (position_um_i >= delay_q);
    cmd_o.bound     = position_um_i - delay_q;
    cmd_o.pos       = position_um_i;
    cmd_o.value     = data_value_i;
    cmd_o.rank      = data_rank_i;
  end

endmodule

// File: rtl/pdl_cmd_fifo.sv
// two-entry command queue between front and back
module pdl_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pdl_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output pdl_pkg::cmd_t cmd_o
);

  pdl_pkg::cmd_t slot_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// File: rtl/pdl_back.sv
// back end: entry ring in ram, head drop scan and result register
`include "assert_macros.svh"

module pdl_back #(
  parameter int unsigned QUEUE_DEPTH = 256,
  localparam int unsigned AW = $clog2(QUEUE_DEPTH),
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cmd_valid_i,
  input  pdl_pkg::cmd_t                    cmd_i,
  output logic                             pop_o,
  output logic                             result_valid_o,
  output logic signed [pdl_pkg::VAL_W-1:0] delayed_value_o,
  output logic [pdl_pkg::RANK_W-1:0]       delayed_rank_o,
  output logic [CW-1:0]                    queue_fill_o,
  output logic                             overflow_o
);

  typedef enum logic {ST_IDLE, ST_CHECK} state_e;

  state_e                    state_q, state_d;
  logic [AW-1:0]             head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]             count_q, count_d;
  logic                      ovf_q, ovf_d;
  logic                      has_bound_q, has_bound_d;
  logic [pdl_pkg::POS_W-1:0] bound_q, bound_d;
  logic                      res_valid_q, res_valid_d;
  logic signed [pdl_pkg::VAL_W-1:0] res_value_q, res_value_d;
  logic [pdl_pkg::RANK_W-1:0] res_rank_q, res_rank_d;
  logic [CW-1:0]             res_fill_q, res_fill_d;
  logic                      res_ovf_q, res_ovf_d;

  logic                         we;
  logic [pdl_pkg::ENTRY_W-1:0]  wdata, rdata;
  logic [pdl_pkg::POS_W-1:0]    rd_pos;
  logic                         drop;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  pdl_ram #(
    .WIDTH (pdl_pkg::ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (tail_q),
    .wdata_i (wdata),
    .raddr_i (head_d),
    .rdata_o (rdata)
  );

  assign wdata  = {cmd_i.pos, cmd_i.value, cmd_i.rank};
  assign rd_pos = rdata[pdl_pkg::ENTRY_W-1 -: pdl_pkg::POS_W];
  assign drop   = has_bound_q && (rd_pos < bound_q);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    has_bound_d = has_bound_q;
    bound_d     = bound_q;
    res_valid_d = 1'b0;
    res_value_d = res_value_q;
    res_rank_d  = res_rank_q;
    res_fill_d  = res_fill_q;
    res_ovf_d   = res_ovf_q;
    pop_o       = 1'b0;
    we          = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          if (cmd_i.seam) begin
            head_d  = '0;
            tail_d  = '0;
            count_d = '0;
          end else begin
            we          = 1'b1;
            tail_d      = ptr_inc(tail_q);
            has_bound_d = cmd_i.has_bound;
            bound_d     = cmd_i.bound;
            if (count_q == CW'(QUEUE_DEPTH)) begin
              head_d = ptr_inc(head_q);
              ovf_d  = 1'b1;
            end else begin
              count_d = count_q + CW'(1);
              ovf_d   = 1'b0;
            end
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (drop) begin
          head_d  = ptr_inc(head_q);
          count_d = count_q - CW'(1);
        end else begin
          res_valid_d = 1'b1;
          res_value_d = rdata[pdl_pkg::VAL_W+pdl_pkg::RANK_W-1 -: pdl_pkg::VAL_W];
          res_rank_d  = rdata[pdl_pkg::RANK_W-1:0];
          res_fill_d  = count_q;
          res_ovf_d   = ovf_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      has_bound_q <= 1'b0;
      bound_q     <= '0;
      res_valid_q <= 1'b0;
      res_value_q <= '0;
      res_rank_q  <= '0;
      res_fill_q  <= '0;
      res_ovf_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      has_bound_q <= has_bound_d;
      bound_q     <= bound_d;
      res_valid_q <= res_valid_d;
      res_value_q <= res_value_d;
      res_rank_q  <= res_rank_d;
      res_fill_q  <= res_fill_d;
      res_ovf_q   <= res_ovf_d;
    end
  end

  assign result_valid_o  = res_valid_q;
  assign delayed_value_o = res_value_q;
  assign delayed_rank_o  = res_rank_q;
  assign queue_fill_o    = res_fill_q;
  assign overflow_o      = res_ovf_q;

  `PDL_ASSERT_IMPLY(a_fill_nonzero, res_valid_q, res_fill_q != '0)
  `PDL_ASSERT_NEXT(a_strobe_single, res_valid_q, !res_valid_q)
  `PDL_ASSERT_IMPLY(a_empty_ptrs, count_q == '0, head_q == tail_q)
  `PDL_ASSERT_IMPLY(a_scan_keeps_entry, state_q == ST_CHECK, count_q != '0)

endmodule

// File: rtl/position_delay_line.sv
// top level of the encoder position delay line
//
// usage:
//   command channel: an item is taken at a rising edge with start high and busy
//   low. req_type_i selects a data sample or a seam start; a seam start empties
//   the queue and gives no result.
//   config channel: cfg_data_i sets the delay in micrometres on a transfer with
//   cfg_valid_i and cfg_ready_o high; write it only while the block is idle.
//   result channel: result_valid_o is high for one cycle per data sample with
//   the delayed value, its rank, the fill after the step and the overflow flag.
//   the receiver cannot stall; each result must be taken in its cycle.
// sequencing:
//   a sample is taken from the command queue and written at the tail; the drop
//   scan reads one ram entry per cycle and drops head entries whose position
//   is below the bound, and the result is registered after it. a seam start
//   only empties the queue. a two-entry command queue lets start be taken
//   while the back end scans.
// reset: delay returns to 100 um and the queue is empty; no ram clearing pass.
module position_delay_line #(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             req_type_i,
  input  logic [pdl_pkg::POS_W-1:0]        position_um_i,
  input  logic signed [pdl_pkg::VAL_W-1:0] data_value_i,
  input  logic [pdl_pkg::RANK_W-1:0]       data_rank_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pdl_pkg::POS_W-1:0]        cfg_data_i,
  output logic                             result_valid_o,
  output logic signed [pdl_pkg::VAL_W-1:0] delayed_value_o,
  output logic [pdl_pkg::RANK_W-1:0]       delayed_rank_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_fill_o,
  output logic                             overflow_o
);

  logic          fifo_full, push, pop, cmd_valid;
  pdl_pkg::cmd_t front_cmd, back_cmd;

  pdl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type_i),
    .position_um_i (position_um_i),
    .data_value_i  (data_value_i),
    .data_rank_i   (data_rank_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .fifo_full_i   (fifo_full),
    .push_o        (push),
    .cmd_o         (front_cmd)
  );

  pdl_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .valid_o (cmd_valid),
    .cmd_o   (back_cmd)
  );

  pdl_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (back_cmd),
    .pop_o           (pop),
    .result_valid_o  (result_valid_o),
    .delayed_value_o (delayed_value_o),
    .delayed_rank_o  (delayed_rank_o),
    .queue_fill_o    (queue_fill_o),
    .overflow_o      (overflow_o)
  );

endmodule
